// ===== design/lpht_pkg.sv =====
// Package for the linear probing hash table: request, response and slot
// entry types, operation and status codes, and the control state types.
// No dependencies.
package lpht_pkg;

  localparam int unsigned TABLE_SIZE_DEF = 1024;
  localparam int unsigned HASH_W         = 32;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned SLOT_W         = 10;

  // Operation codes. Code 3 has no meaning of its own and acts as a lookup.
  typedef enum logic [1:0] {
    OP_LOOKUP        = 2'd0,
    OP_INSERT        = 2'd1,
    OP_LOOKUP_INSERT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_MISS     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_READ,
    S_CHECK
  } state_e;

  // Steps of the home slot unit for a table size that is not a power of two.
  typedef enum logic [1:0] {
    M_IDLE,
    M_RECIP,
    M_BACK,
    M_FIX
  } mod_step_e;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [HASH_W-1:0]         position_hash;
    logic [HASH_W-1:0]         check_hash_a;
    logic [HASH_W-1:0]         check_hash_b;
    logic signed [VALUE_W-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [SLOT_W-1:0]         slot_index;
    logic signed [VALUE_W-1:0] found_value;
  } rsp_t;

  typedef struct packed {
    logic                      valid;
    logic [HASH_W-1:0]         check_a;
    logic [HASH_W-1:0]         check_b;
    logic signed [VALUE_W-1:0] value;
  } slot_entry_t;

endpackage

// ===== design/linear_probe_hash_table.sv =====
// Top level of the linear probing hash table: probe sequencer, request and
// result registers. Depends on lpht_pkg, lpht_mod and lpht_store.
//
//   channel  direction  handshake              word
//   in       input      in_valid_i/in_stall_o   req_t (opcode, hashes, value)
//   out      output     out_valid_o/out_stall_i rsp_t (status, slot, value)
//
// After reset a clearing pass writes every slot empty, with in_stall_o high.
// A request is accepted in S_IDLE, then the home slot unit runs, then each
// probed slot takes a store read (S_READ) and a compare (S_CHECK). A request
// is taken while the previous result waits in the output register; a finished
// probe holds until that register is free.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);

  state_e        state_q, state_d;
  req_t          req_q;
  logic [AW-1:0] home_q, home_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] clr_q;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_q, out_d;

  logic          accept;
  logic          mod_done;
  logic [AW-1:0] mod_rem;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_entry_t   wr_entry;
  logic          rd_en;
  slot_entry_t   rd_entry;

  logic          hit;
  logic [AW-1:0] nxt;
  logic          wrap;
  logic          term;
  status_e       res_status;
  logic          out_free;
  logic          load;

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  lpht_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (in_data_i.position_hash),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  lpht_store #(.TABLE_SIZE(TABLE_SIZE)) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry),
    .rd_en_i    (rd_en),
    .rd_addr_i  (pos_q),
    .rd_entry_o (rd_entry)
  );

  // Probe decision on the slot just read.
  always_comb begin
    hit        = rd_entry.valid && (rd_entry.check_a == req_q.check_hash_a) &&
                 (rd_entry.check_b == req_q.check_hash_b);
    nxt        = (pos_q == LAST_SLOT) ? '0 : pos_q + AW'(1);
    wrap       = (nxt == home_q);
    term       = 1'b1;
    res_status = ST_MISS;
    case (req_q.opcode)
      OP_INSERT: begin
        if (!rd_entry.valid) begin
          res_status = ST_INSERTED;
        end else if (wrap) begin
          res_status = ST_FULL;
        end else begin
          term = 1'b0;
        end
      end
      OP_LOOKUP_INSERT: begin
        // The lookup stops at the first empty slot, which is also where the
        // insert would land.
        if (hit) begin
          res_status = ST_FOUND;
        end else if (!rd_entry.valid) begin
          res_status = ST_INSERTED;
        end else if (wrap) begin
          res_status = ST_FULL;
        end else begin
          term = 1'b0;
        end
      end
      default: begin
        if (hit) begin
          res_status = ST_FOUND;
        end else if (!rd_entry.valid || wrap) begin
          res_status = ST_MISS;
        end else begin
          term = 1'b0;
        end
      end
    endcase
  end

  assign load = (state_q == S_CHECK) && term && out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == LAST_SLOT) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_HOME;
        end
      end
      S_HOME: begin
        if (mod_done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!term) begin
          state_d = S_READ;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath controls and results.
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    rd_en       = (state_q == S_READ);
    home_d      = home_q;
    pos_d       = pos_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_entry    = '0;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
      end
      S_HOME: begin
        if (mod_done) begin
          home_d = mod_rem;
          pos_d  = mod_rem;
        end
      end
      S_CHECK: begin
        if (!term) begin
          pos_d = nxt;
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      out_valid_d         = 1'b1;
      out_d.status        = res_status;
      out_d.slot_index    = '0;
      out_d.found_value   = '0;
      if ((res_status == ST_FOUND) || (res_status == ST_INSERTED)) begin
        out_d.slot_index = SLOT_W'(pos_q);
      end
      if (res_status == ST_FOUND) begin
        out_d.found_value = rd_entry.value;
      end
      if (res_status == ST_INSERTED) begin
        wr_en            = 1'b1;
        wr_entry.valid   = 1'b1;
        wr_entry.check_a = req_q.check_hash_a;
        wr_entry.check_b = req_q.check_hash_b;
        wr_entry.value   = req_q.entry_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    home_q <= home_d;
    pos_q  <= pos_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/lpht_mod.sv =====
// Home slot unit: remainder of the position hash by the table size.
// Reciprocal multiplication on one shared multiplier in the steps M_RECIP and
// M_BACK with a correction in M_FIX, or a plain mask for a power-of-two table size. Depends on lpht_pkg.
module lpht_mod import lpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [HASH_W-1:0] dividend_i,
  output logic              done_o,
  output logic [AW-1:0]     rem_o
);

  localparam bit                IS_POW2   = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
  localparam int unsigned       SHIFT     = HASH_W + AW - 1;
  // The scaled reciprocal fits 32 bits because the size is above 2**(AW-1).
  localparam longint unsigned   RECIP_L   = (64'd1 << SHIFT) / TABLE_SIZE;
  localparam logic [HASH_W-1:0] RECIP     = HASH_W'(RECIP_L);
  localparam logic [HASH_W-1:0] DIVISOR   = HASH_W'(TABLE_SIZE);
  localparam logic [AW:0]       DIVISOR_N = (AW + 1)'(TABLE_SIZE);

  mod_step_e           step_q, step_d;
  logic                done_q, done_d;
  logic [HASH_W-1:0]   x_q, x_d;
  logic [2*HASH_W-1:0] prod_q, prod_d;
  logic [AW-1:0]       rem_q, rem_d;

  logic [HASH_W-1:0]   mul_a;
  logic [HASH_W-1:0]   mul_b;
  logic [2*HASH_W-1:0] prod;
  logic [HASH_W-1:0]   quot;
  logic [HASH_W-1:0]   diff;
  logic [AW:0]         part;

  // The quotient estimate is the true quotient or one less, so the
  // remainder left after the back multiplication needs one subtract at most.
  assign quot  = HASH_W'(prod_q >> SHIFT);
  assign mul_a = (step_q == M_BACK) ? quot : x_q;
  assign mul_b = (step_q == M_BACK) ? DIVISOR : RECIP;
  assign prod  = {{HASH_W{1'b0}}, mul_a} * {{HASH_W{1'b0}}, mul_b};
  assign diff  = x_q - prod_q[HASH_W-1:0];
  assign part  = diff[AW:0];

  // Next step.
  always_comb begin
    step_d = step_q;
    case (step_q)
      M_IDLE: begin
        if (start_i && !IS_POW2) begin
          step_d = M_RECIP;
        end
      end
      M_RECIP: begin
        step_d = M_BACK;
      end
      M_BACK: begin
        step_d = M_FIX;
      end
      M_FIX: begin
        step_d = M_IDLE;
      end
      default: begin
        step_d = M_IDLE;
      end
    endcase
  end

  // Datapath per step.
  always_comb begin
    done_d = 1'b0;
    x_d    = x_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    case (step_q)
      M_IDLE: begin
        if (start_i) begin
          if (IS_POW2) begin
            rem_d  = dividend_i[AW-1:0];
            done_d = 1'b1;
          end else begin
            x_d = dividend_i;
          end
        end
      end
      M_RECIP: begin
        prod_d = prod;
      end
      M_BACK: begin
        prod_d = prod;
      end
      M_FIX: begin
        if (part >= DIVISOR_N) begin
          rem_d = AW'(part - DIVISOR_N);
        end else begin
          rem_d = part[AW-1:0];
        end
        done_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= M_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/lpht_store.sv =====
// Slot store: one write port and one registered read port over the slot
// entries (valid mark, both check hashes, payload). Depends on lpht_pkg.
module lpht_store import lpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  slot_entry_t wr_entry_i,
  input  logic        rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output slot_entry_t rd_entry_o
);

  slot_entry_t mem [TABLE_SIZE];
  slot_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

// ===== design/lpht_checker.sv =====
// Port checker for the linear probing hash table and its bind to the top
// level. Depends on lpht_pkg.
module lpht_checker import lpht_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_data_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // One request at a time: the block is busy right after taking a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while a probe is in progress");

  // Miss and full report neither a slot nor a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.status == ST_MISS) || (out_data_o.status == ST_FULL))
    |-> (out_data_o.slot_index == '0) && (out_data_o.found_value == '0))
    else $error("miss or full result carries a slot or value");

  // An insert reports no value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_INSERTED) |-> (out_data_o.found_value == '0))
    else $error("insert result carries a value");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== bench/linear_probe_hash_table_tb.sv =====
// Self-checking testbench for linear_probe_hash_table: lookups, inserts and
// lookup-inserts against a shadow table, up to a full table, under random stalls.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_SIZE = TABLE_SIZE_DEF;
  // Code 3 has no enum member; the block treats it as a lookup.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT_NS = 20_000_000;

  typedef struct packed {
    logic [HASH_W-1:0] ph;
    logic [HASH_W-1:0] ca;
    logic [HASH_W-1:0] cb;
  } key_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  // Shadow copy of the slot store.
  bit                  tbl_used [TBL_SIZE];
  logic [HASH_W-1:0]   tbl_chk_a [TBL_SIZE];
  logic [HASH_W-1:0]   tbl_chk_b [TBL_SIZE];
  logic [VALUE_W-1:0]  tbl_val [TBL_SIZE];

  req_t  req_q [$];
  rsp_t  rsp_due_q [$];
  key_t  known_keys [$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int snd_quiet = 0;
  int rcv_quiet = 0;
  int n_taken = 0;
  int n_seen = 0;
  int n_err = 0;
  int n_status [4] = '{0, 0, 0, 0};
  rsp_t due;
  rsp_t want;

  linear_probe_hash_table #(.TABLE_SIZE(TBL_SIZE)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial forever #10 clk_i = ~clk_i;

  // Applies one request to the shadow table and returns the response word.
  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    int unsigned home, pos, where;
    bit hit, placed, done;
    o = '0;
    home = r.position_hash % TBL_SIZE;
    hit = 1'b0;
    placed = 1'b0;
    where = 0;
    if (r.opcode != OP_INSERT) begin
      pos = home;
      done = 1'b0;
      while (!done) begin
        if (!tbl_used[pos]) begin
          done = 1'b1;
        end else if (tbl_chk_a[pos] == r.check_hash_a && tbl_chk_b[pos] == r.check_hash_b) begin
          hit = 1'b1;
          where = pos;
          done = 1'b1;
        end else begin
          pos = (pos + 1 == TBL_SIZE) ? 0 : pos + 1;
          done = (pos == home);
        end
      end
    end
    if (r.opcode == OP_INSERT || (r.opcode == OP_LOOKUP_INSERT && !hit)) begin
      pos = home;
      done = 1'b0;
      while (!done) begin
        if (!tbl_used[pos]) begin
          placed = 1'b1;
          done = 1'b1;
        end else begin
          pos = (pos + 1 == TBL_SIZE) ? 0 : pos + 1;
          done = (pos == home);
        end
      end
      if (placed) begin
        tbl_used[pos] = 1'b1;
        tbl_chk_a[pos] = r.check_hash_a;
        tbl_chk_b[pos] = r.check_hash_b;
        tbl_val[pos] = r.entry_value;
        o.status = ST_INSERTED;
        o.slot_index = pos[SLOT_W-1:0];
      end else begin
        o.status = ST_FULL;
      end
    end else if (hit) begin
      o.status = ST_FOUND;
      o.slot_index = where[SLOT_W-1:0];
      o.found_value = tbl_val[where];
    end else begin
      o.status = ST_MISS;
    end
    return o;
  endfunction

  task automatic queue_req(input logic [1:0] op, input logic [HASH_W-1:0] ph,
                           input logic [HASH_W-1:0] ca, input logic [HASH_W-1:0] cb,
                           input logic [VALUE_W-1:0] val);
    req_t r;
    r.opcode = op;
    r.position_hash = ph;
    r.check_hash_a = ca;
    r.check_hash_b = cb;
    r.entry_value = val;
    req_q.push_back(r);
    if (op == OP_INSERT || op == OP_LOOKUP_INSERT)
      known_keys.push_back('{ph, ca, cb});
  endtask

  // A key already sent for insertion, reached through a different position
  // hash with the same home slot.
  function automatic key_t pick_known();
    key_t k;
    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
    k.ph[HASH_W-1:SLOT_W] = (HASH_W - SLOT_W)'($urandom());
    return k;
  endfunction

  function automatic key_t fresh_key();
    key_t k;
    k.ph = $urandom();
    k.ca = $urandom();
    k.cb = $urandom();
    // Crowd some keys at both ends of the table so probes wrap.
    if ($urandom_range(0, 5) == 0)
      k.ph[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 1) ?
                                 $urandom_range(TBL_SIZE - 16, TBL_SIZE - 1) :
                                 $urandom_range(0, 15));
    return k;
  endfunction

  task automatic random_burst(input int n);
    key_t k;
    int pick;
    logic [VALUE_W-1:0] val;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      val = $urandom();
      case ($urandom_range(0, 19))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = 32'hFFFF_FFFF;
        3: val = 32'h0;
        default: ;
      endcase
      if (known_keys.size() == 0 && pick < 48)
        pick = 60;
      if (pick < 48)
        k = pick_known();
      else
        k = fresh_key();
      if (pick < 30) begin
        queue_req(OP_LOOKUP, k.ph, k.ca, k.cb, val);
      end else if (pick < 38) begin
        queue_req(OP_LOOKUP_INSERT, k.ph, k.ca, k.cb, val);
      end else if (pick < 42) begin
        queue_req(OP_UNUSED, k.ph, k.ca, k.cb, val);
      end else if (pick < 48) begin
        // Near miss: one check hash differs in a single bit.
        if ($urandom_range(0, 1))
          k.ca ^= 32'd1 << $urandom_range(0, 31);
        else
          k.cb ^= 32'd1 << $urandom_range(0, 31);
        queue_req(OP_LOOKUP, k.ph, k.ca, k.cb, val);
      end else if (pick < 58) begin
        queue_req(OP_LOOKUP, k.ph, k.ca, k.cb, val);
      end else if (pick < 60) begin
        queue_req(OP_UNUSED, k.ph, k.ca, k.cb, val);
      end else if (pick < 85) begin
        queue_req(OP_INSERT, k.ph, k.ca, k.cb, val);
      end else if (pick < 92 && known_keys.size() != 0) begin
        k = pick_known();
        queue_req(OP_INSERT, k.ph, k.ca, k.cb, val);
      end else begin
        queue_req(OP_LOOKUP_INSERT, k.ph, k.ca, k.cb, val);
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_q.size() != 0 || in_valid_i || rsp_due_q.size() != 0);
  endtask

  // Driver: presents queued request words and predicts each one as it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        due = table_apply(in_data_i);
        rsp_due_q.push_back(due);
        n_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (snd_quiet != 0)
          snd_quiet--;
        else if ($urandom_range(0, 299) == 0)
          snd_quiet = $urandom_range(10, 60);
        if (req_q.size() != 0 &&
            (snd_quiet != 0 || $urandom_range(0, 99) >= snd_idle_pct)) begin
          in_valid_i <= 1'b1;
          in_data_i <= req_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each response word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_seen++;
        if (rsp_due_q.size() == 0) begin
          if (n_err < 10)
            $display("tb: response %0d arrived with none pending: status %0d slot %0d value %0d",
                     n_seen, out_data_o.status, out_data_o.slot_index, out_data_o.found_value);
          n_err++;
        end else begin
          want = rsp_due_q.pop_front();
          n_status[want.status]++;
          if (out_data_o.status !== want.status || out_data_o.slot_index !== want.slot_index ||
              out_data_o.found_value !== want.found_value) begin
            if (n_err < 10)
              $display("tb: response %0d mismatch: status %0d/%0d slot %0d/%0d value %0d/%0d",
                       n_seen, want.status, out_data_o.status, want.slot_index,
                       out_data_o.slot_index, want.found_value, out_data_o.found_value);
            n_err++;
          end
        end
      end
      if (rcv_quiet != 0) begin
        rcv_quiet--;
        out_stall_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 299) == 0)
          rcv_quiet = $urandom_range(10, 60);
        out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  initial begin
    key_t k;
    snd_idle_pct <= 30;
    rcv_idle_pct <= 56;

    // Directed part, starting from an empty table.
    queue_req(OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_req(OP_INSERT, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
    queue_req(OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h1234);
    queue_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    // Home is the last slot and both it and slot 0 are taken, so this lands in slot 1.
    queue_req(OP_INSERT, 32'h0000_03FF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
    queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0);
    // Duplicate key goes further along; the lookup still finds the first copy.
    queue_req(OP_INSERT, 32'h0000_0400, 32'h0, 32'h0, 32'hFFFF_FFFF);
    queue_req(OP_LOOKUP, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    queue_req(OP_LOOKUP_INSERT, 32'h0000_0005, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001);
    queue_req(OP_LOOKUP_INSERT, 32'h7FFF_FC05, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
    queue_req(OP_UNUSED, 32'h0000_0005, 32'hFFFF_FFFF, 32'h0, 32'h0);
    queue_req(OP_UNUSED, 32'h0000_0005, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(OP_LOOKUP, 32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
    queue_req(OP_LOOKUP, 32'h0000_0005, 32'h7FFF_FFFF, 32'h0, 32'h0);
    queue_req(OP_LOOKUP, 32'h0000_03FE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    queue_req(OP_LOOKUP, 32'h0000_03FF, 32'h0, 32'h0, 32'h0);
    queue_req(OP_INSERT, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_req(OP_LOOKUP_INSERT, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_req(OP_LOOKUP, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0);
    random_burst(150);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    snd_idle_pct <= 56;
    rcv_idle_pct <= 30;
    random_burst(150);
    wait_drained();

    snd_idle_pct <= 0;
    rcv_idle_pct <= 0;
    random_burst(75);
    wait_drained();

    // Fill every empty slot through its own home, leaving the table full.
    for (int s = 0; s < TBL_SIZE; s++) begin
      if (!tbl_used[s]) begin
        k = fresh_key();
        k.ph[SLOT_W-1:0] = SLOT_W'(s);
        queue_req(OP_INSERT, k.ph, k.ca, k.cb, $urandom());
      end
    end
    wait_drained();

    // Full table: inserts are refused and misses walk all the way round.
    repeat (3) begin
      k = fresh_key();
      queue_req(OP_INSERT, k.ph, k.ca, k.cb, $urandom());
    end
    repeat (2) begin
      k = fresh_key();
      queue_req(OP_LOOKUP_INSERT, k.ph, k.ca, k.cb, $urandom());
    end
    k = fresh_key();
    queue_req(OP_LOOKUP, k.ph, k.ca, k.cb, $urandom());
    k = fresh_key();
    queue_req(OP_UNUSED, k.ph, k.ca, k.cb, $urandom());
    repeat (4) begin
      k = pick_known();
      queue_req(OP_LOOKUP, k.ph, k.ca, k.cb, $urandom());
    end
    k = pick_known();
    queue_req(OP_LOOKUP_INSERT, k.ph, k.ca, k.cb, $urandom());
    wait_drained();

    repeat (50) @(posedge clk_i);
    $display("tb: %0d requests, %0d responses checked, %0d mismatches", n_taken, n_seen, n_err);
    $display("tb: found %0d, missed %0d, inserted %0d, refused on full table %0d",
             n_status[ST_FOUND], n_status[ST_MISS], n_status[ST_INSERTED], n_status[ST_FULL]);
    if (n_err == 0 && rsp_due_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
design/lpht_pkg.sv
design/lpht_mod.sv
design/lpht_store.sv
design/linear_probe_hash_table.sv
design/lpht_checker.sv
bench/linear_probe_hash_table_tb.sv
